[rtl/page_table_allocator_translator_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the page table allocator and translator.
// ---------------------------------------------------------------------------
`ifndef PAGE_TABLE_ALLOCATOR_TRANSLATOR_DEFINES_SVH
`define PAGE_TABLE_ALLOCATOR_TRANSLATOR_DEFINES_SVH

// Check a property on the rising clock edge, ignored while reset is low.
`define PTA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds while reset is released.
`define PTA_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/pta_pkg.sv]
// ---------------------------------------------------------------------------
// pta_pkg
// Shared constants, codes and types of the page table allocator.
// ---------------------------------------------------------------------------
package pta_pkg;

	localparam int PAGE_TOTAL    = 64;
	localparam int PAGE_BYTES    = 256;
	localparam int POINTER_BASE  = 64;
	localparam int MEM_DEPTH     = PAGE_TOTAL * PAGE_BYTES;
	localparam int TABLE_ENTRIES = (PAGE_TOTAL < PAGE_BYTES) ? PAGE_TOTAL : PAGE_BYTES;
	localparam int ADDR_W        = $clog2(MEM_DEPTH);
	localparam int OFF_W         = $clog2(PAGE_BYTES);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [7:0]        byte_t;

	typedef enum logic [2:0] {
		OP_NEW   = 3'd0,
		OP_ADD   = 3'd1,
		OP_KILL  = 3'd2,
		OP_STORE = 3'd3,
		OP_LOAD  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_TABLE = 3'd1,
		ST_NO_DATA  = 3'd2,
		ST_FULL     = 3'd3,
		ST_FAULT    = 3'd4,
		ST_NO_PROC  = 3'd5
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR,      // reset sweep of memory
		S_IDLE,
		S_PTR_RD,     // read pointer slot
		S_PTR_WT,
		S_GRAB_RD,    // scan free map for a page
		S_GRAB_WT,
		S_TCLR,       // clear new table page
		S_TCLR_PTR,   // write pointer slot with the new table
		S_FE_RD,      // scan table for empty entry
		S_FE_WT,
		S_MAP_WR,     // write entry with new page
		S_KILL_RD,
		S_KILL_WT,
		S_KILL_FREE,
		S_KILL_TBL,
		S_KILL_PTR,
		S_XL_RD,      // translate: read entry
		S_XL_WT,
		S_DATA,       // data access
		S_DATA_WT,
		S_DONE
	} state_t;

	// Memory request from the sequencer.
	typedef struct packed {
		logic  rd;
		logic  wr;
		addr_t addr;
		byte_t wdata;
	} mem_req_t;

	function automatic addr_t page_addr(input logic [7:0] page, input logic [8:0] off);
		logic [31:0] a;
		a = 32'(page) * 32'(PAGE_BYTES) + 32'(off);
		return addr_t'(a);
	endfunction

endpackage

[rtl/pta_mem.sv]
// ---------------------------------------------------------------------------
// pta_mem
// Single-port byte memory with registered read.
// ---------------------------------------------------------------------------
module pta_mem
	import pta_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output byte_t    rdata
);

	byte_t mem_q [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rdata <= mem_q[req.addr];
		end
	end

endmodule

[rtl/page_table_allocator_translator.sv]
// New and add scan the free map and the table (new also clears the table page), and
// kill scans the table, all through the single memory port; store and load read
// the table entry, then access the data byte.
// Throughput: one transaction at a time; in_stall is high until the result is taken.
// Reset: asynchronous, active low; afterwards a sweep clears all PAGE_TOTAL*PAGE_BYTES
// bytes of the memory (marking page 0 used) before the first transaction.
// ---------------------------------------------------------------------------
// page_table_allocator_translator
// Paged memory with free map, per-process tables and address translation.
// ---------------------------------------------------------------------------
`include "page_table_allocator_translator_defines.svh"

module page_table_allocator_translator
	import pta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [7:0]  process,
	input  logic [6:0]  page_request,
	input  logic [13:0] virtual_address,
	input  logic [7:0]  write_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  read_byte,
	output logic [13:0] physical_address
);

	localparam int CNT_W = ADDR_W + 1;

	state_t state_q, state_d;
	mem_req_t req;
	byte_t rdata;

	// Transaction registers.
	logic [2:0]  op_q;
	logic [8:0]  slot_q;
	logic [6:0]  req_q;
	logic [13:0] va_q;
	byte_t       wb_q;
	byte_t       table_q;
	byte_t       page_q;
	logic [8:0]  idx_q;      // scan index (free map or table entry)
	logic [6:0]  left_q;     // pages still to allocate
	logic        add_chk_q;  // add: first empty scan is the fullness test
	logic [CNT_W-1:0] clr_q;
	status_t     st_q;
	byte_t       rb_q;
	logic [13:0] pa_q;
	logic        out_valid_q;

	logic accept;
	logic [31:0] data_a;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status = st_q;
	assign read_byte = rb_q;
	assign physical_address = pa_q;

	assign data_a = 32'(page_q) * 32'(PAGE_BYTES) + 32'(va_q[OFF_W-1:0]);

	pta_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:     if (clr_q == CNT_W'(MEM_DEPTH - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					if (operation > 3'(OP_LOAD)) state_d = S_DONE;
					else if ({1'b0, process} + 9'(POINTER_BASE) >= 9'(PAGE_BYTES))
						state_d = S_DONE;
					else if (operation == 3'(OP_NEW)) state_d = S_GRAB_RD;
					else state_d = S_PTR_RD;
				end
			end
			S_PTR_RD:    state_d = S_PTR_WT;
			S_PTR_WT: begin
				if (rdata == '0) state_d = S_DONE;
				else if (op_q == 3'(OP_ADD)) state_d = S_FE_RD;
				else if (op_q == 3'(OP_KILL)) state_d = S_KILL_RD;
				else if ({1'b0, va_q[13:OFF_W]} >= 7'(TABLE_ENTRIES)) state_d = S_DONE;
				else state_d = S_XL_RD;
			end
			S_GRAB_RD:   state_d = S_GRAB_WT;
			S_GRAB_WT: begin
				if (rdata == '0) state_d = (table_q == '0) ? S_TCLR : S_MAP_WR;
				else if (idx_q == 9'(PAGE_TOTAL - 1)) state_d = S_DONE;
				else state_d = S_GRAB_RD;
			end
			S_TCLR: begin
				if (idx_q == 9'(PAGE_BYTES - 1)) state_d = S_TCLR_PTR;
			end
			S_TCLR_PTR:  state_d = (req_q == '0) ? S_DONE : S_FE_RD;
			S_FE_RD:     state_d = S_FE_WT;
			S_FE_WT: begin
				if (rdata == '0) begin
					if (add_chk_q && left_q == '0) state_d = S_DONE;
					else state_d = S_GRAB_RD;
				end else if (idx_q == 9'(TABLE_ENTRIES - 1)) state_d = S_DONE;
				else state_d = S_FE_RD;
			end
			S_MAP_WR:    state_d = (left_q == 7'd1) ? S_DONE : S_FE_RD;
			S_KILL_RD:   state_d = S_KILL_WT;
			S_KILL_WT:   state_d = (rdata != '0 && rdata < 8'(PAGE_TOTAL)) ? S_KILL_FREE :
				(idx_q == 9'(TABLE_ENTRIES - 1)) ? S_KILL_TBL : S_KILL_RD;
			S_KILL_FREE: state_d = (idx_q == 9'(TABLE_ENTRIES - 1)) ? S_KILL_TBL : S_KILL_RD;
			S_KILL_TBL:  state_d = S_KILL_PTR;
			S_KILL_PTR:  state_d = S_DONE;
			S_XL_RD:     state_d = S_XL_WT;
			S_XL_WT:     state_d = (rdata == '0) ? S_DONE : S_DATA;
			S_DATA:      state_d = (op_q == 3'(OP_STORE)) ? S_DONE : S_DATA_WT;
			S_DATA_WT:   state_d = S_DONE;
			// Hold the result until the downstream side takes it.
			S_DONE:      if (out_valid_q && !out_stall) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// Memory port requests.
	always_comb begin
		req = '0;
		case (state_q)
			S_CLEAR: begin
				req.wr = 1'b1;
				req.addr = clr_q[ADDR_W-1:0];
				req.wdata = (clr_q == '0) ? 8'd1 : 8'd0;
			end
			S_PTR_RD: begin
				req.rd = 1'b1;
				req.addr = addr_t'(slot_q);
			end
			S_GRAB_RD: begin
				req.rd = 1'b1;
				req.addr = addr_t'(idx_q);
			end
			S_GRAB_WT: begin
				// Mark the free page used as soon as it is found.
				req.wr = (rdata == '0);
				req.addr = addr_t'(idx_q);
				req.wdata = 8'd1;
			end
			S_TCLR: begin
				req.wr = 1'b1;
				req.addr = page_addr(table_q, idx_q);
			end
			S_TCLR_PTR: begin
				req.wr = 1'b1;
				req.addr = addr_t'(slot_q);
				req.wdata = table_q;
			end
			S_FE_RD, S_KILL_RD: begin
				req.rd = 1'b1;
				req.addr = page_addr(table_q, idx_q);
			end
			S_MAP_WR: begin
				req.wr = 1'b1;
				req.addr = page_addr(table_q, va_q[8:0]);
				req.wdata = page_q;
			end
			S_KILL_FREE: begin
				req.wr = 1'b1;
				req.addr = addr_t'(page_q);
			end
			S_KILL_TBL: begin
				req.wr = (table_q < 8'(PAGE_TOTAL));
				req.addr = addr_t'(table_q);
			end
			S_KILL_PTR: begin
				req.wr = 1'b1;
				req.addr = addr_t'(slot_q);
			end
			S_XL_RD: begin
				req.rd = 1'b1;
				req.addr = page_addr(table_q, {3'b000, va_q[13:OFF_W]});
			end
			S_DATA: begin
				req.rd = (op_q == 3'(OP_LOAD));
				req.wr = (op_q == 3'(OP_STORE));
				req.addr = addr_t'(data_a);
				req.wdata = wb_q;
			end
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			// Drop the result once the downstream side takes it.
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			else if (state_q == S_DONE && !out_valid_q) out_valid_q <= 1'b1;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= operation;
				slot_q <= {1'b0, process} + 9'(POINTER_BASE);
				req_q <= page_request;
				left_q <= page_request;
				va_q <= virtual_address;
				wb_q <= write_byte;
				table_q <= '0;
				idx_q <= 9'd1;
				add_chk_q <= (operation == 3'(OP_ADD));
				rb_q <= '0;
				pa_q <= '0;
				st_q <= ({1'b0, process} + 9'(POINTER_BASE) >= 9'(PAGE_BYTES) &&
					operation <= 3'(OP_LOAD)) ? ST_NO_PROC : ST_OK;
			end
			S_PTR_WT: begin
				table_q <= rdata;
				idx_q <= '0;
				if (rdata == '0) st_q <= ST_NO_PROC;
				else if (op_q != 3'(OP_ADD) && op_q != 3'(OP_KILL) &&
					{1'b0, va_q[13:OFF_W]} >= 7'(TABLE_ENTRIES)) st_q <= ST_FAULT;
			end
			S_GRAB_WT: begin
				if (rdata == '0) begin
					if (table_q == '0) table_q <= 8'(idx_q);
					else page_q <= 8'(idx_q);
					idx_q <= (table_q == '0) ? 9'd0 : idx_q;
				end else if (idx_q == 9'(PAGE_TOTAL - 1)) begin
					st_q <= (table_q == '0) ? ST_NO_TABLE : ST_NO_DATA;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_TCLR: begin
				if (idx_q == 9'(PAGE_BYTES - 1)) idx_q <= '0;
				else idx_q <= idx_q + 1'b1;
			end
			S_FE_WT: begin
				if (rdata == '0) begin
					add_chk_q <= 1'b0;
					page_q <= '0;
					// Save the empty entry in va_q; scan the free map next.
					va_q[8:0] <= idx_q;
					idx_q <= 9'd1;
				end else if (idx_q == 9'(TABLE_ENTRIES - 1)) begin
					st_q <= ST_FULL;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_MAP_WR: begin
				left_q <= left_q - 1'b1;
				idx_q <= '0;
			end
			S_KILL_WT: begin
				page_q <= rdata;
				if (!(rdata != '0 && rdata < 8'(PAGE_TOTAL))) idx_q <= idx_q + 1'b1;
			end
			S_KILL_FREE: idx_q <= idx_q + 1'b1;
			S_XL_WT: begin
				page_q <= rdata;
				if (rdata == '0) st_q <= ST_FAULT;
				else pa_q <= 14'(32'(rdata) * 32'(PAGE_BYTES) + 32'(va_q[OFF_W-1:0]));
			end
			S_DATA_WT: rb_q <= rdata;
			default: ;
		endcase
	end

	`PTA_NEVER(a_busy_accept, in_stall && state_q == S_IDLE, "stall high while idle")
	`PTA_ASSERT(a_out_done, $rose(out_valid) |-> $past(state_q) == S_DONE, "result outside done")
	`PTA_ASSERT(a_status_rng, out_valid |-> status <= 3'(ST_NO_PROC), "bad status code")

endmodule
